>>> hdl/svgpn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svgpn_pkg
// Shared types, codes and helpers of the path segment normalizer.
// ----------------------------------------------------------------------------
package svgpn_pkg;

    typedef enum logic [3:0] {
        ACT_CLOSE   = 4'd0,
        ACT_MOVE    = 4'd1,
        ACT_LINE    = 4'd2,
        ACT_CUBIC   = 4'd3,
        ACT_QUAD    = 4'd4,
        ACT_HLINE   = 4'd5,
        ACT_VLINE   = 4'd6,
        ACT_SCUBIC  = 4'd7,
        ACT_SQUAD   = 4'd8,
        ACT_END     = 4'd9,
        ACT_NONE    = 4'd15
    } act_t;

    typedef enum logic [2:0] {
        PRIM_MOVETO   = 3'd0,
        PRIM_LINETO   = 3'd1,
        PRIM_CUBIC    = 3'd2,
        PRIM_CLOSE    = 3'd3,
        PRIM_FINISHED = 3'd4
    } prim_t;

    // How the back end turns a queued record into a result.
    typedef enum logic [2:0] {
        RK_POINT,    // scale and offset the target point only
        RK_RAW,      // pass the target point through unscaled
        RK_CAPLINE,  // unscaled target plus the tiny cap length in x
        RK_CUBIC,    // scale all three points
        RK_QUAD,     // convert start, control, end to a cubic, then scale
        RK_FIN       // path finished marker
    } rec_kind_t;

    typedef enum logic [2:0] {
        CFG_ZOOM         = 3'd0,
        CFG_OFFSET_X     = 3'd1,
        CFG_OFFSET_Y     = 3'd2,
        CFG_LINE_CAPS_ON = 3'd3,
        CFG_STROKE_WIDTH = 3'd4
    } cfg_index_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DSET,
        B_DIV,
        B_MUL,
        B_ACC,
        B_CAP_MUL,
        B_CAP_Q,
        B_CAP_FIX,
        B_OUT
    } back_state_t;

    localparam int FL_STARTED = 0;
    localparam int FL_INVALID = 1;
    localparam int FL_LENGTH  = 2;
    localparam int FL_NONMOVE = 3;

    typedef struct packed {
        prim_t               prim;
        rec_kind_t           kind;
        logic                inv;
        logic                last;
        logic signed [31:0]  ax;
        logic signed [31:0]  ay;
        logic signed [31:0]  bx;
        logic signed [31:0]  by;
        logic signed [31:0]  ex;
        logic signed [31:0]  ey;
    } rec_t;

    localparam logic signed [39:0] SAT_MAX = 40'sh007FFFFFFF;
    localparam logic signed [39:0] SAT_MIN = 40'shFF80000000;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7FFFFFFF;
        end else if (v < SAT_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hdl/svgpn_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svgpn_fifo
// Four-entry record queue between the command front end and the back end.
// ----------------------------------------------------------------------------
module svgpn_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  svgpn_pkg::rec_t    wdata,
    output logic               full,
    input  wire logic          pop,
    output svgpn_pkg::rec_t    rdata,
    output logic               empty
);
    import svgpn_pkg::*;

    localparam int DEPTH = 4;

    rec_t       mem_reg [DEPTH];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] cnt_reg;

    assign full  = (cnt_reg == 3'(DEPTH));
    assign empty = (cnt_reg == 3'd0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            cnt_reg    <= 3'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 3'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 3'd1;
            end
        end
    end

endmodule
`default_nettype wire

>>> hdl/svgpn_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svgpn_front
// Accepts path commands, keeps the path state and turns each command into
// zero to three unscaled primitive records for the back end.
// ----------------------------------------------------------------------------
module svgpn_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [3:0]          s_action,
    input  wire logic                s_relative,
    input  wire logic signed [31:0]  s_ctrl1_x,
    input  wire logic signed [31:0]  s_ctrl1_y,
    input  wire logic signed [31:0]  s_ctrl2_x,
    input  wire logic signed [31:0]  s_ctrl2_y,
    input  wire logic signed [31:0]  s_end_x,
    input  wire logic signed [31:0]  s_end_y,
    input  wire logic                line_caps_on,
    input  wire logic [30:0]         stroke_width,
    output logic                     push,
    output svgpn_pkg::rec_t          push_rec,
    input  wire logic                q_full
);
    import svgpn_pkg::*;

    logic signed [31:0] sub_x_reg, sub_y_reg, seg_x_reg, seg_y_reg;
    logic signed [31:0] pc1x_reg, pc1y_reg, pc2x_reg, pc2y_reg;
    logic signed [31:0] sub_x_next, sub_y_next, seg_x_next, seg_y_next;
    logic signed [31:0] pc1x_next, pc1y_next, pc2x_next, pc2y_next;
    logic [3:0]         kind_reg, kind_next;
    logic [3:0]         fl_reg, fl_next;

    rec_t               pend_reg [3];
    logic [1:0]         pend_cnt_reg;
    rec_t               recs [3];
    logic [1:0]         nrec;

    logic               accept;

    function automatic logic signed [31:0] absl(input logic rel,
                                                input logic signed [31:0] s,
                                                input logic signed [31:0] v);
        logic signed [31:0] r;
        r = rel ? sat32(40'(s) + 40'(v)) : v;
        return r;
    endfunction

    function automatic rec_t mkrec(input prim_t p, input rec_kind_t k,
                                   input logic signed [31:0] ex,
                                   input logic signed [31:0] ey);
        rec_t r;
        r      = '0;
        r.prim = p;
        r.kind = k;
        r.ex   = ex;
        r.ey   = ey;
        return r;
    endfunction

    assign s_ready  = (pend_cnt_reg == 2'd0);
    assign accept   = s_valid && s_ready;
    assign push     = (pend_cnt_reg != 2'd0) && !q_full;
    assign push_rec = pend_reg[0];

    always_comb begin
        logic               rel;
        logic signed [31:0] sx, sy, ax, ay, bx, by, ex, ey;
        logic               cap_base, cap_close, cap_other, inv;
        rec_t               r;

        rel        = s_relative;
        sx         = seg_x_reg;
        sy         = seg_y_reg;
        ax         = sx;
        ay         = sy;
        bx         = sx;
        by         = sy;
        ex         = sx;
        ey         = sy;
        r          = '0;
        nrec       = 2'd0;
        for (int i = 0; i < 3; i++) begin
            recs[i] = '0;
        end
        sub_x_next = sub_x_reg;
        sub_y_next = sub_y_reg;
        seg_x_next = seg_x_reg;
        seg_y_next = seg_y_reg;
        pc1x_next  = pc1x_reg;
        pc1y_next  = pc1y_reg;
        pc2x_next  = pc2x_reg;
        pc2y_next  = pc2y_reg;
        kind_next  = kind_reg;
        fl_next    = fl_reg;

        // A close marks the subpath as drawn before the cap check.
        cap_base  = !fl_reg[FL_LENGTH] && line_caps_on && (stroke_width != 31'd0)
                    && (kind_reg != ACT_NONE);
        cap_close = cap_base;
        cap_other = cap_base && fl_reg[FL_NONMOVE] && (kind_reg != ACT_MOVE);
        inv       = !fl_reg[FL_STARTED] || fl_reg[FL_INVALID];

        if (accept && s_action <= ACT_END) begin
            if (s_action == ACT_END) begin
                if (!inv && cap_other) begin
                    recs[0] = mkrec(PRIM_LINETO, RK_CAPLINE, sx, sy);
                    recs[1] = mkrec(PRIM_MOVETO, RK_RAW, sx, sy);
                    nrec    = 2'd2;
                end
                r        = mkrec(PRIM_FINISHED, RK_FIN, 32'sd0, 32'sd0);
                r.inv    = inv;
                recs[nrec] = r;
                nrec     = nrec + 2'd1;
                sub_x_next = '0;
                sub_y_next = '0;
                seg_x_next = '0;
                seg_y_next = '0;
                pc1x_next  = '0;
                pc1y_next  = '0;
                pc2x_next  = '0;
                pc2y_next  = '0;
                kind_next  = ACT_NONE;
                fl_next    = 4'd0;
            end else if (fl_reg[FL_INVALID]) begin
                nrec = 2'd0;
            end else if (!fl_reg[FL_STARTED] && s_action != ACT_MOVE) begin
                fl_next[FL_STARTED] = 1'b1;
                fl_next[FL_INVALID] = 1'b1;
            end else begin
                fl_next[FL_STARTED] = 1'b1;
                unique case (s_action) inside
                    ACT_CLOSE: begin
                        if (cap_close) begin
                            recs[0] = mkrec(PRIM_LINETO, RK_CAPLINE, sx, sy);
                            recs[1] = mkrec(PRIM_MOVETO, RK_RAW, sx, sy);
                            nrec    = 2'd2;
                        end
                        ex = sub_x_reg;
                        ey = sub_y_reg;
                        recs[nrec] = mkrec(PRIM_CLOSE, RK_POINT, ex, ey);
                        nrec       = nrec + 2'd1;
                    end
                    ACT_MOVE: begin
                        if (cap_other) begin
                            recs[0] = mkrec(PRIM_LINETO, RK_CAPLINE, sx, sy);
                            recs[1] = mkrec(PRIM_MOVETO, RK_RAW, sx, sy);
                            nrec    = 2'd2;
                        end
                        ex = absl(rel, sx, s_end_x);
                        ey = absl(rel, sy, s_end_y);
                        sub_x_next = ex;
                        sub_y_next = ey;
                        recs[nrec] = mkrec(PRIM_MOVETO, RK_POINT, ex, ey);
                        nrec       = nrec + 2'd1;
                        fl_next[FL_LENGTH] = 1'b0;
                    end
                    ACT_LINE, ACT_HLINE, ACT_VLINE: begin
                        if (s_action != ACT_VLINE) begin
                            ex = absl(rel, sx, s_end_x);
                        end
                        if (s_action != ACT_HLINE) begin
                            ey = absl(rel, sy, s_end_y);
                        end
                        if (ex != sx || ey != sy) begin
                            fl_next[FL_LENGTH] = 1'b1;
                            recs[0] = mkrec(PRIM_LINETO, RK_POINT, ex, ey);
                            nrec    = 2'd1;
                        end
                    end
                    ACT_CUBIC, ACT_SCUBIC: begin
                        if (s_action == ACT_CUBIC) begin
                            ax = absl(rel, sx, s_ctrl1_x);
                            ay = absl(rel, sy, s_ctrl1_y);
                        end else if (kind_reg == ACT_CUBIC || kind_reg == ACT_SCUBIC) begin
                            ax = sat32((40'(sx) <<< 1) - 40'(pc2x_reg));
                            ay = sat32((40'(sy) <<< 1) - 40'(pc2y_reg));
                        end
                        bx = absl(rel, sx, s_ctrl2_x);
                        by = absl(rel, sy, s_ctrl2_y);
                        ex = absl(rel, sx, s_end_x);
                        ey = absl(rel, sy, s_end_y);
                        pc1x_next = ax;
                        pc1y_next = ay;
                        pc2x_next = bx;
                        pc2y_next = by;
                        if (ex != sx || ey != sy || ex != ax || ey != ay
                            || ex != bx || ey != by) begin
                            fl_next[FL_LENGTH] = 1'b1;
                            r      = mkrec(PRIM_CUBIC, RK_CUBIC, ex, ey);
                            r.ax   = ax;
                            r.ay   = ay;
                            r.bx   = bx;
                            r.by   = by;
                            recs[0] = r;
                            nrec    = 2'd1;
                        end
                    end
                    default: begin
                        if (s_action == ACT_QUAD) begin
                            ax = absl(rel, sx, s_ctrl1_x);
                            ay = absl(rel, sy, s_ctrl1_y);
                        end else if (kind_reg == ACT_QUAD || kind_reg == ACT_SQUAD) begin
                            ax = sat32((40'(sx) <<< 1) - 40'(pc1x_reg));
                            ay = sat32((40'(sy) <<< 1) - 40'(pc1y_reg));
                        end
                        ex = absl(rel, sx, s_end_x);
                        ey = absl(rel, sy, s_end_y);
                        pc1x_next = ax;
                        pc1y_next = ay;
                        if (ex != sx || ey != sy || ex != ax || ey != ay) begin
                            fl_next[FL_LENGTH] = 1'b1;
                            // Start, control and end travel as-is; the back end
                            // derives the cubic control points.
                            r      = mkrec(PRIM_CUBIC, RK_QUAD, ex, ey);
                            r.ax   = sx;
                            r.ay   = sy;
                            r.bx   = ax;
                            r.by   = ay;
                            recs[0] = r;
                            nrec    = 2'd1;
                        end
                    end
                endcase
                fl_next[FL_NONMOVE] = (s_action != ACT_MOVE);
                kind_next  = s_action;
                seg_x_next = ex;
                seg_y_next = ey;
            end
            if (nrec != 2'd0) begin
                recs[nrec - 2'd1].last = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < 3; i++) begin
                pend_reg[i] <= recs[i];
            end
        end else if (push) begin
            pend_reg[0] <= pend_reg[1];
            pend_reg[1] <= pend_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_cnt_reg <= 2'd0;
            sub_x_reg    <= '0;
            sub_y_reg    <= '0;
            seg_x_reg    <= '0;
            seg_y_reg    <= '0;
            pc1x_reg     <= '0;
            pc1y_reg     <= '0;
            pc2x_reg     <= '0;
            pc2y_reg     <= '0;
            kind_reg     <= ACT_NONE;
            fl_reg       <= 4'd0;
        end else begin
            if (accept) begin
                pend_cnt_reg <= nrec;
            end else if (push) begin
                pend_cnt_reg <= pend_cnt_reg - 2'd1;
            end
            sub_x_reg <= sub_x_next;
            sub_y_reg <= sub_y_next;
            seg_x_reg <= seg_x_next;
            seg_y_reg <= seg_y_next;
            pc1x_reg  <= pc1x_next;
            pc1y_reg  <= pc1y_next;
            pc2x_reg  <= pc2x_next;
            pc2y_reg  <= pc2y_next;
            kind_reg  <= kind_next;
            fl_reg    <= fl_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/svgpn_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svgpn_back
// Executes queued primitive records: quadratic to cubic conversion with a
// divide by three through a small reciprocal multiply, scaling through one
// shared multiplier, the cap length, and the result register.
// ----------------------------------------------------------------------------
module svgpn_back #(
    parameter int FRAC_BITS   = 16,
    parameter int CAP_DIVISOR = 512
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                rec_valid,
    input  svgpn_pkg::rec_t          rec,
    output logic                     pop,
    input  wire logic [31:0]         zoom,
    input  wire logic signed [31:0]  offset_x,
    input  wire logic signed [31:0]  offset_y,
    input  wire logic [30:0]         stroke_width,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [2:0]               m_prim,
    output logic signed [31:0]       m_out_c1_x,
    output logic signed [31:0]       m_out_c1_y,
    output logic signed [31:0]       m_out_c2_x,
    output logic signed [31:0]       m_out_c2_y,
    output logic signed [31:0]       m_out_x,
    output logic signed [31:0]       m_out_y,
    output logic                     m_invalid,
    output logic                     m_last
);
    import svgpn_pkg::*;

    localparam logic [15:0]        DIV3_HI   = 16'd43690;
    localparam logic [19:0]        RECIP3    = 20'd699051;
    localparam logic [31:0]        CAP_HALF  = 32'(CAP_DIVISOR / 2);
    localparam logic [32:0]        CAP_RECIP = 33'((64'd1 << 32) / CAP_DIVISOR);
    localparam logic [32:0]        CAP_D     = 33'(CAP_DIVISOR);
    localparam logic signed [65:0] RND       = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [65:0] SC_MAX    = 66'sd2147483647;
    localparam logic signed [65:0] SC_MIN    = -66'sd2147483648;

    back_state_t        state_reg, state_next;
    rec_t               cur_reg, cur_next;
    logic signed [31:0] crd_reg [6];
    logic signed [31:0] crd_next [6];
    logic [2:0]         idx_reg, idx_next;
    logic [1:0]         j_reg, j_next;
    logic [34:0]        dv_reg, dv_next;
    logic               ph_reg, ph_next;
    logic               neg_reg, neg_next;
    logic signed [65:0] prod_reg, prod_next;
    logic [31:0]        tiny_reg, tiny_next;

    logic               mv_reg, mv_next;
    logic [2:0]         mprim_reg, mprim_next;
    logic signed [31:0] mc1x_reg, mc1y_reg, mc2x_reg, mc2y_reg, mx_reg, my_reg;
    logic               minv_reg, minv_next, mlast_reg, mlast_next;
    logic               m_load;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [31:0]        cap_num;

    assign mul_p   = mul_a * mul_b;
    assign cap_num = {1'b0, stroke_width} + CAP_HALF;

    assign m_valid    = mv_reg;
    assign m_prim     = mprim_reg;
    assign m_out_c1_x = mc1x_reg;
    assign m_out_c1_y = mc1y_reg;
    assign m_out_c2_x = mc2x_reg;
    assign m_out_c2_y = mc2y_reg;
    assign m_out_x    = mx_reg;
    assign m_out_y    = my_reg;
    assign m_invalid  = minv_reg;
    assign m_last     = mlast_reg;

    always_comb begin
        logic signed [31:0] base, other;
        logic signed [32:0] diff;
        logic signed [34:0] num;
        logic [16:0]        dh, dl;
        logic [18:0]        fold;
        logic [38:0]        fq;
        logic signed [35:0] qd;
        logic signed [65:0] sc;
        logic signed [31:0] off;
        logic [32:0]        rmd;
        logic [31:0]        tiny_f;

        state_next = state_reg;
        cur_next   = cur_reg;
        for (int i = 0; i < 6; i++) begin
            crd_next[i] = crd_reg[i];
        end
        idx_next   = idx_reg;
        j_next     = j_reg;
        dv_next    = dv_reg;
        ph_next    = ph_reg;
        neg_next   = neg_reg;
        prod_next  = prod_reg;
        tiny_next  = tiny_reg;
        pop        = 1'b0;
        m_load     = 1'b0;
        mul_a      = 33'(crd_reg[idx_reg]);
        mul_b      = $signed({1'b0, zoom});
        base       = crd_reg[0];
        other      = crd_reg[2];
        diff       = '0;
        num        = '0;
        dh         = '0;
        dl         = '0;
        fold       = '0;
        fq         = '0;
        qd         = '0;
        sc         = '0;
        off        = idx_reg[0] ? offset_y : offset_x;
        rmd        = '0;
        tiny_f     = '0;

        case (j_reg)
            2'd0: begin
                base  = crd_reg[0];
                other = crd_reg[2];
            end
            2'd1: begin
                base  = crd_reg[1];
                other = crd_reg[3];
            end
            2'd2: begin
                base  = crd_reg[2];
                other = crd_reg[4];
            end
            default: begin
                base  = crd_reg[3];
                other = crd_reg[5];
            end
        endcase

        unique case (state_reg)
            B_IDLE: begin
                if (rec_valid) begin
                    pop         = 1'b1;
                    cur_next    = rec;
                    crd_next[0] = rec.ax;
                    crd_next[1] = rec.ay;
                    crd_next[2] = rec.bx;
                    crd_next[3] = rec.by;
                    crd_next[4] = rec.ex;
                    crd_next[5] = rec.ey;
                    j_next      = 2'd0;
                    unique case (rec.kind)
                        RK_POINT: begin
                            idx_next   = 3'd4;
                            state_next = B_MUL;
                        end
                        RK_CUBIC: begin
                            idx_next   = 3'd0;
                            state_next = B_MUL;
                        end
                        RK_QUAD:    state_next = B_DSET;
                        RK_CAPLINE: state_next = B_CAP_MUL;
                        default:    state_next = B_OUT;
                    endcase
                end
            end
            B_DSET: begin
                // t1 = s + round(2(c-s)/3) and t2 = c + round((e-c)/3).
                diff     = 33'(other) - 33'(base);
                num      = (j_reg[1] == 1'b0) ? (35'(diff) <<< 1) : 35'(diff);
                neg_next = num[34];
                dv_next  = (num[34] ? 35'(-num) : 35'(num)) + 35'd1;
                ph_next  = 1'b0;
                state_next = B_DIV;
            end
            B_DIV: begin
                if (!ph_reg) begin
                    // With v = h * 2^17 + l and 2^17 = 3 * 43690 + 2, the
                    // quotient is 43690 * h + (2h + l) / 3.
                    dh      = dv_reg[33:17];
                    dl      = dv_reg[16:0];
                    fold    = 19'({dh, 1'b0}) + 19'(dl);
                    fq      = 39'(fold) * 39'(RECIP3);
                    dv_next = 35'(33'(dh) * 33'(DIV3_HI) + 33'(fq[38:21]));
                    ph_next = 1'b1;
                end else begin
                    qd = $signed({1'b0, dv_reg});
                    qd = neg_reg ? -qd : qd;
                    crd_next[{1'b0, j_reg}] = sat32(40'(base) + 40'(qd));
                    if (j_reg == 2'd3) begin
                        idx_next   = 3'd0;
                        state_next = B_MUL;
                    end else begin
                        j_next     = j_reg + 2'd1;
                        state_next = B_DSET;
                    end
                end
            end
            B_MUL: begin
                prod_next  = mul_p;
                state_next = B_ACC;
            end
            B_ACC: begin
                sc = ((prod_reg + RND) >>> FRAC_BITS) + 66'(off);
                if (sc > SC_MAX) begin
                    crd_next[idx_reg] = 32'sh7FFFFFFF;
                end else if (sc < SC_MIN) begin
                    crd_next[idx_reg] = 32'sh80000000;
                end else begin
                    crd_next[idx_reg] = sc[31:0];
                end
                if (idx_reg == 3'd5) begin
                    state_next = B_OUT;
                end else begin
                    idx_next   = idx_reg + 3'd1;
                    state_next = B_MUL;
                end
            end
            B_CAP_MUL: begin
                // Reciprocal estimate of the cap length, corrected below.
                mul_a      = $signed({1'b0, cap_num});
                mul_b      = $signed(CAP_RECIP);
                prod_next  = mul_p;
                state_next = B_CAP_Q;
            end
            B_CAP_Q: begin
                mul_a      = $signed({1'b0, prod_reg[63:32]});
                mul_b      = $signed(CAP_D);
                tiny_next  = prod_reg[63:32];
                prod_next  = mul_p;
                state_next = B_CAP_FIX;
            end
            B_CAP_FIX: begin
                rmd    = {1'b0, cap_num} - prod_reg[32:0];
                tiny_f = (rmd >= CAP_D) ? tiny_reg + 32'd1 : tiny_reg;
                crd_next[4] = sat32(40'(crd_reg[4]) + 40'({1'b0, tiny_f}));
                state_next  = B_OUT;
            end
            B_OUT: begin
                if (!mv_reg || m_ready) begin
                    m_load     = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    assign mv_next    = m_load ? 1'b1 : (mv_reg && !m_ready);
    assign mprim_next = cur_reg.prim;
    assign minv_next  = cur_reg.inv;
    assign mlast_next = cur_reg.last;

    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        for (int i = 0; i < 6; i++) begin
            crd_reg[i] <= crd_next[i];
        end
        idx_reg  <= idx_next;
        j_reg    <= j_next;
        dv_reg   <= dv_next;
        ph_reg   <= ph_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        tiny_reg <= tiny_next;
        if (m_load) begin
            mprim_reg <= mprim_next;
            mc1x_reg  <= crd_reg[0];
            mc1y_reg  <= crd_reg[1];
            mc2x_reg  <= crd_reg[2];
            mc2y_reg  <= crd_reg[3];
            mx_reg    <= crd_reg[4];
            my_reg    <= crd_reg[5];
            minv_reg  <= minv_next;
            mlast_reg <= mlast_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/svg_path_segment_normalizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svg_path_segment_normalizer
// Turns a stream of path commands into absolute, scaled cubic-based
// primitives (moveto, lineto, cubic, close, path finished).
//
// Input channel s_*: one path command per item (valid/ready). Result
// channel m_*: zero to three primitives per command, m_last on the final one.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata; the user
// must write it only while the block is idle, which the block itself does
// not enforce. Writes take effect at once. The front end takes a command and
// forwards its records to a four-entry queue at one per cycle while the queue
// is not full; it takes the next command once its records are queued. The
// back end sets the rate: one shared multiplier scales one coordinate at a
// time, a quadratic first goes through its four divisions by three, and the
// back end takes a new record only once it has passed the last one to the
// output register.
// When the receiver stalls, one result waits in the output register, the
// back end holds, the queue fills, and s_ready then drops.
// Reset clears the path state, the queue and the output valid, and loads the
// registers with zoom 1.0, zero offsets, caps off and zero stroke width.
// ----------------------------------------------------------------------------
module svg_path_segment_normalizer #(
    parameter int CAP_DIVISOR = 512,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [31:0]         cfg_wdata,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [3:0]          s_action,
    input  wire logic                s_relative,
    input  wire logic signed [31:0]  s_ctrl1_x,
    input  wire logic signed [31:0]  s_ctrl1_y,
    input  wire logic signed [31:0]  s_ctrl2_x,
    input  wire logic signed [31:0]  s_ctrl2_y,
    input  wire logic signed [31:0]  s_end_x,
    input  wire logic signed [31:0]  s_end_y,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [2:0]               m_prim,
    output logic signed [31:0]       m_out_c1_x,
    output logic signed [31:0]       m_out_c1_y,
    output logic signed [31:0]       m_out_c2_x,
    output logic signed [31:0]       m_out_c2_y,
    output logic signed [31:0]       m_out_x,
    output logic signed [31:0]       m_out_y,
    output logic                     m_invalid,
    output logic                     m_last
);
    import svgpn_pkg::*;

    logic [31:0]        zoom_reg;
    logic signed [31:0] offset_x_reg, offset_y_reg;
    logic               caps_reg;
    logic [30:0]        stroke_width_reg;

    logic               q_push, q_full, q_pop, q_empty;
    rec_t               q_wdata, q_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zoom_reg         <= 32'd65536;
            offset_x_reg     <= '0;
            offset_y_reg     <= '0;
            caps_reg         <= 1'b0;
            stroke_width_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ZOOM:         zoom_reg         <= cfg_wdata;
                CFG_OFFSET_X:     offset_x_reg     <= $signed(cfg_wdata);
                CFG_OFFSET_Y:     offset_y_reg     <= $signed(cfg_wdata);
                CFG_LINE_CAPS_ON: caps_reg         <= cfg_wdata[0];
                CFG_STROKE_WIDTH: stroke_width_reg <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    svgpn_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_relative   (s_relative),
        .s_ctrl1_x    (s_ctrl1_x),
        .s_ctrl1_y    (s_ctrl1_y),
        .s_ctrl2_x    (s_ctrl2_x),
        .s_ctrl2_y    (s_ctrl2_y),
        .s_end_x      (s_end_x),
        .s_end_y      (s_end_y),
        .line_caps_on (caps_reg),
        .stroke_width (stroke_width_reg),
        .push         (q_push),
        .push_rec     (q_wdata),
        .q_full       (q_full)
    );

    svgpn_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .empty   (q_empty)
    );

    svgpn_back #(
        .FRAC_BITS   (FRAC_BITS),
        .CAP_DIVISOR (CAP_DIVISOR)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .rec_valid    (!q_empty),
        .rec          (q_rdata),
        .pop          (q_pop),
        .zoom         (zoom_reg),
        .offset_x     (offset_x_reg),
        .offset_y     (offset_y_reg),
        .stroke_width (stroke_width_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_prim       (m_prim),
        .m_out_c1_x   (m_out_c1_x),
        .m_out_c1_y   (m_out_c1_y),
        .m_out_c2_x   (m_out_c2_x),
        .m_out_c2_y   (m_out_c2_y),
        .m_out_x      (m_out_x),
        .m_out_y      (m_out_y),
        .m_invalid    (m_invalid),
        .m_last       (m_last)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("record pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("record popped from an empty queue");

    a_invalid_only_on_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_invalid) |-> (m_prim == PRIM_FINISHED))
        else $error("invalid flag on a drawing primitive");

    a_finish_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_prim == PRIM_FINISHED) |-> m_last)
        else $error("path finished item not marked last");
`endif

endmodule
`default_nettype wire

>>> tb/sv/tb_svg_path_segment_normalizer.sv
// ----------------------------------------------------------------------------
// tb_svg_path_segment_normalizer
// Self-checking testbench for the path segment normalizer. Path commands are
// sent through the valid/ready input channel, and a predictor built into the
// bench works out the primitives that each command should produce. Every
// primitive that comes out is checked field by field against the oldest
// expected one. The run covers directed paths, invalid paths, cap insertion,
// extreme register settings, a long output stall and random paths.
// ----------------------------------------------------------------------------
module tb_svg_path_segment_normalizer;
    import svgpn_pkg::*;

    localparam int  CAP_DIV        = 512;
    localparam int  IDLE_LIMIT     = 20000;
    localparam int  SETTLE_CYCLES  = 250;
    localparam logic [3:0] ACT_UNUSED_LO = 4'd10;
    localparam logic [3:0] ACT_UNUSED_HI = 4'd15;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;
    localparam logic signed [31:0] Q_ONE = 32'sh00010000;

    typedef struct {
        logic [3:0]         act;
        logic               rel;
        logic signed [31:0] c1x, c1y, c2x, c2y, ex, ey;
    } path_cmd_t;

    typedef struct {
        logic [2:0]         prim;
        logic signed [31:0] c1x, c1y, c2x, c2y, x, y;
        logic               inv;
        logic               last;
    } prim_rec_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [3:0]         s_action = '0;
    logic               s_relative = 1'b0;
    logic signed [31:0] s_ctrl1_x = '0, s_ctrl1_y = '0, s_ctrl2_x = '0, s_ctrl2_y = '0;
    logic signed [31:0] s_end_x = '0, s_end_y = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [2:0]         m_prim;
    logic signed [31:0] m_out_c1_x, m_out_c1_y, m_out_c2_x, m_out_c2_y, m_out_x, m_out_y;
    logic               m_invalid, m_last;

    svg_path_segment_normalizer dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_relative(s_relative), .s_ctrl1_x(s_ctrl1_x), .s_ctrl1_y(s_ctrl1_y),
        .s_ctrl2_x(s_ctrl2_x), .s_ctrl2_y(s_ctrl2_y),
        .s_end_x(s_end_x), .s_end_y(s_end_y),
        .m_valid(m_valid), .m_ready(m_ready), .m_prim(m_prim),
        .m_out_c1_x(m_out_c1_x), .m_out_c1_y(m_out_c1_y),
        .m_out_c2_x(m_out_c2_x), .m_out_c2_y(m_out_c2_y),
        .m_out_x(m_out_x), .m_out_y(m_out_y),
        .m_invalid(m_invalid), .m_last(m_last)
    );

    always #6 aclk = ~aclk;

    // Predictor copy of the registers and the path state.
    logic [31:0]        p_zoom = 32'd65536;
    logic signed [31:0] p_off_x = '0, p_off_y = '0;
    logic               p_caps = 1'b0;
    logic [30:0]        p_width = '0;
    logic signed [31:0] sub_x, sub_y, seg_x, seg_y;
    logic signed [31:0] pc1_x, pc1_y, pc2_x, pc2_y;
    logic [3:0]         prev_act;
    logic [3:0]         flags;

    prim_rec_t expected_prims[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_cycles = 0;
    int idle_count = 0;

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > longint'(Q_MAX)) return Q_MAX;
        if (v < longint'(Q_MIN)) return Q_MIN;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] zoom_pt(input logic signed [31:0] p,
                                                  input logic signed [31:0] off);
        longint v;
        v = longint'(p) * longint'({32'b0, p_zoom}) + 64'sd32768;
        return clamp32((v >>> 16) + longint'(off));
    endfunction

    function automatic logic signed [31:0] abs_pt(input logic rel,
                                                 input logic signed [31:0] s,
                                                 input logic signed [31:0] v);
        return rel ? clamp32(longint'(s) + longint'(v)) : v;
    endfunction

    function automatic longint third(input longint n);
        return n >= 0 ? (n + 1) / 3 : -((-n + 1) / 3);
    endfunction

    function automatic void emit(input logic [2:0] prim,
                                 input logic signed [31:0] ax, ay, bx, by, x, y,
                                 input logic inv);
        prim_rec_t r;
        r = '{prim, ax, ay, bx, by, x, y, inv, 1'b0};
        expected_prims.push_back(r);
    endfunction

    function automatic void clear_path();
        sub_x = 0; sub_y = 0; seg_x = 0; seg_y = 0;
        pc1_x = 0; pc1_y = 0; pc2_x = 0; pc2_y = 0;
        prev_act = ACT_NONE;
        flags = '0;
    endfunction

    // A subpath without length gets a short unscaled lineto and a moveto back.
    function automatic void cap_fix(input logic is_close);
        longint tiny;
        if (!flags[FL_LENGTH] && p_caps && p_width != 0 && flags[FL_NONMOVE] &&
            prev_act != ACT_NONE && (prev_act != ACT_MOVE || is_close)) begin
            tiny = (longint'(p_width) + CAP_DIV / 2) / CAP_DIV;
            emit(PRIM_LINETO, 0, 0, 0, 0, clamp32(longint'(seg_x) + tiny), seg_y, 1'b0);
            emit(PRIM_MOVETO, 0, 0, 0, 0, seg_x, seg_y, 1'b0);
        end
    endfunction

    function automatic void predict_cmd(input path_cmd_t c);
        int n_prior;
        logic signed [31:0] sx, sy, ex, ey, ax, ay, bx, by, t1x, t1y, t2x, t2y;
        n_prior = expected_prims.size();
        sx = seg_x; sy = seg_y; ex = sx; ey = sy;
        if (c.act > ACT_END) return;
        if (c.act == ACT_END) begin
            if (!flags[FL_STARTED] || flags[FL_INVALID]) begin
                emit(PRIM_FINISHED, 0, 0, 0, 0, 0, 0, 1'b1);
            end else begin
                cap_fix(1'b0);
                emit(PRIM_FINISHED, 0, 0, 0, 0, 0, 0, 1'b0);
            end
            expected_prims[$].last = 1'b1;
            clear_path();
            return;
        end
        if (flags[FL_INVALID]) return;
        if (!flags[FL_STARTED]) begin
            flags[FL_STARTED] = 1'b1;
            if (c.act != ACT_MOVE) begin
                flags[FL_INVALID] = 1'b1;
                return;
            end
        end
        case (c.act)
            ACT_CLOSE: begin
                flags[FL_NONMOVE] = 1'b1;
                cap_fix(1'b1);
                ex = sub_x; ey = sub_y;
                emit(PRIM_CLOSE, 0, 0, 0, 0, zoom_pt(ex, p_off_x), zoom_pt(ey, p_off_y), 1'b0);
            end
            ACT_MOVE: begin
                cap_fix(1'b0);
                ex = abs_pt(c.rel, sx, c.ex); ey = abs_pt(c.rel, sy, c.ey);
                sub_x = ex; sub_y = ey;
                emit(PRIM_MOVETO, 0, 0, 0, 0, zoom_pt(ex, p_off_x), zoom_pt(ey, p_off_y), 1'b0);
                flags[FL_LENGTH] = 1'b0;
            end
            ACT_LINE, ACT_HLINE, ACT_VLINE: begin
                if (c.act != ACT_VLINE) ex = abs_pt(c.rel, sx, c.ex);
                if (c.act != ACT_HLINE) ey = abs_pt(c.rel, sy, c.ey);
                if (ex != sx || ey != sy) begin
                    flags[FL_LENGTH] = 1'b1;
                    emit(PRIM_LINETO, 0, 0, 0, 0, zoom_pt(ex, p_off_x),
                         zoom_pt(ey, p_off_y), 1'b0);
                end
            end
            ACT_CUBIC, ACT_SCUBIC: begin
                if (c.act == ACT_CUBIC) begin
                    ax = abs_pt(c.rel, sx, c.c1x); ay = abs_pt(c.rel, sy, c.c1y);
                end else if (prev_act == ACT_CUBIC || prev_act == ACT_SCUBIC) begin
                    ax = clamp32(2 * longint'(sx) - longint'(pc2_x));
                    ay = clamp32(2 * longint'(sy) - longint'(pc2_y));
                end else begin
                    ax = sx; ay = sy;
                end
                bx = abs_pt(c.rel, sx, c.c2x); by = abs_pt(c.rel, sy, c.c2y);
                ex = abs_pt(c.rel, sx, c.ex); ey = abs_pt(c.rel, sy, c.ey);
                pc1_x = ax; pc1_y = ay; pc2_x = bx; pc2_y = by;
                if (ex != sx || ey != sy || ex != ax || ey != ay || ex != bx || ey != by) begin
                    flags[FL_LENGTH] = 1'b1;
                    emit(PRIM_CUBIC, zoom_pt(ax, p_off_x), zoom_pt(ay, p_off_y),
                         zoom_pt(bx, p_off_x), zoom_pt(by, p_off_y),
                         zoom_pt(ex, p_off_x), zoom_pt(ey, p_off_y), 1'b0);
                end
            end
            default: begin
                if (c.act == ACT_QUAD) begin
                    ax = abs_pt(c.rel, sx, c.c1x); ay = abs_pt(c.rel, sy, c.c1y);
                end else if (prev_act == ACT_QUAD || prev_act == ACT_SQUAD) begin
                    ax = clamp32(2 * longint'(sx) - longint'(pc1_x));
                    ay = clamp32(2 * longint'(sy) - longint'(pc1_y));
                end else begin
                    ax = sx; ay = sy;
                end
                ex = abs_pt(c.rel, sx, c.ex); ey = abs_pt(c.rel, sy, c.ey);
                pc1_x = ax; pc1_y = ay;
                if (ex != sx || ey != sy || ex != ax || ey != ay) begin
                    t1x = clamp32(longint'(sx) + third(2 * (longint'(ax) - longint'(sx))));
                    t1y = clamp32(longint'(sy) + third(2 * (longint'(ay) - longint'(sy))));
                    t2x = clamp32(longint'(ax) + third(longint'(ex) - longint'(ax)));
                    t2y = clamp32(longint'(ay) + third(longint'(ey) - longint'(ay)));
                    flags[FL_LENGTH] = 1'b1;
                    emit(PRIM_CUBIC, zoom_pt(t1x, p_off_x), zoom_pt(t1y, p_off_y),
                         zoom_pt(t2x, p_off_x), zoom_pt(t2y, p_off_y),
                         zoom_pt(ex, p_off_x), zoom_pt(ey, p_off_y), 1'b0);
                end
            end
        endcase
        flags[FL_NONMOVE] = (c.act != ACT_MOVE);
        prev_act = c.act;
        seg_x = ex; seg_y = ey;
        if (expected_prims.size() > n_prior) expected_prims[$].last = 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    // Result checker.
    always @(posedge aclk) begin
        prim_rec_t w;
        if (aresetn && m_valid && m_ready) begin
            if (expected_prims.size() == 0) begin
                report_mismatch("unexpected primitive, prim", m_prim, -1);
            end else begin
                w = expected_prims.pop_front();
                if (m_prim !== w.prim) report_mismatch("prim", m_prim, w.prim);
                if (m_out_c1_x !== w.c1x) report_mismatch("c1_x", m_out_c1_x, w.c1x);
                if (m_out_c1_y !== w.c1y) report_mismatch("c1_y", m_out_c1_y, w.c1y);
                if (m_out_c2_x !== w.c2x) report_mismatch("c2_x", m_out_c2_x, w.c2x);
                if (m_out_c2_y !== w.c2y) report_mismatch("c2_y", m_out_c2_y, w.c2y);
                if (m_out_x !== w.x) report_mismatch("x", m_out_x, w.x);
                if (m_out_y !== w.y) report_mismatch("y", m_out_y, w.y);
                if (m_invalid !== w.inv) report_mismatch("invalid", m_invalid, w.inv);
                if (m_last !== w.last) report_mismatch("last", m_last, w.last);
            end
        end
    end

    // Receiver: random back-pressure, or a long counted stall on request.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_cycles > 0) begin
            m_ready <= 1'b0;
            stall_cycles <= stall_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_count <= 0;
        end else if (idle_count >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    // Valid is left high after an item; the next call decides at the next
    // falling edge whether to idle or present a new item.
    task automatic send_cmd(input path_cmd_t c);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= c.act; s_relative <= c.rel;
        s_ctrl1_x <= c.c1x; s_ctrl1_y <= c.c1y;
        s_ctrl2_x <= c.c2x; s_ctrl2_y <= c.c2y;
        s_end_x <= c.ex; s_end_y <= c.ey;
        do @(posedge aclk); while (!s_ready);
        predict_cmd(c);
    endtask

    task automatic cmd(input logic [3:0] act, input logic rel,
                       input logic signed [31:0] c1x, c1y, c2x, c2y, ex, ey);
        path_cmd_t c;
        c = '{act, rel, c1x, c1y, c2x, c2y, ex, ey};
        send_cmd(c);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_prims.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_wdata <= data;
        case (idx)
            CFG_ZOOM:         p_zoom = data;
            CFG_OFFSET_X:     p_off_x = data;
            CFG_OFFSET_Y:     p_off_y = data;
            CFG_LINE_CAPS_ON: p_caps = data[0];
            default:          p_width = data[30:0];
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_regs(input logic [31:0] z, ox, oy, caps, w);
        drain();
        write_reg(CFG_ZOOM, z);
        write_reg(CFG_OFFSET_X, ox);
        write_reg(CFG_OFFSET_Y, oy);
        write_reg(CFG_LINE_CAPS_ON, caps);
        write_reg(CFG_STROKE_WIDTH, w);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? Q_MAX : Q_MIN;
            1, 2:    return $urandom;
            default: return (($urandom_range(40) - 20) <<< 16) + $urandom_range(65535);
        endcase
    endfunction

    task automatic rand_cmd(input logic [3:0] act);
        path_cmd_t c;
        c = '{act, 1'($urandom_range(1)), rand_coord(), rand_coord(), rand_coord(),
              rand_coord(), rand_coord(), rand_coord()};
        // Zero-length segments need relative zeros or repeated points.
        if ($urandom_range(7) == 0) begin
            c.rel = 1'b1;
            c.c1x = 0; c.c1y = 0; c.c2x = 0; c.c2y = 0; c.ex = 0; c.ey = 0;
        end
        send_cmd(c);
    endtask

    task automatic rand_path(inout int items);
        int n;
        n = $urandom_range(1, 10);
        if ($urandom_range(9) < 8) begin
            rand_cmd(ACT_MOVE);
            items++;
        end
        repeat (n) begin
            if ($urandom_range(19) == 0) begin
                rand_cmd(4'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI)));
            end else begin
                rand_cmd(4'($urandom_range(ACT_CLOSE, ACT_SQUAD)));
                items++;
            end
        end
        rand_cmd(ACT_END);
        items++;
    endtask

    task automatic test_directed_segments();
        cmd(ACT_MOVE, 0, 0, 0, 0, 0, Q_ONE, 2 * Q_ONE);
        cmd(ACT_LINE, 0, 0, 0, 0, 0, 5 * Q_ONE, 2 * Q_ONE);
        cmd(ACT_HLINE, 1, 0, 0, 0, 0, -Q_ONE, 0);
        cmd(ACT_VLINE, 0, 0, 0, 0, 0, 0, -3 * Q_ONE);
        cmd(ACT_CUBIC, 1, Q_ONE, 0, 2 * Q_ONE, Q_ONE, 3 * Q_ONE, 3 * Q_ONE);
        cmd(ACT_SCUBIC, 0, 0, 0, 9 * Q_ONE, 9 * Q_ONE, 7 * Q_ONE, 1);
        cmd(ACT_QUAD, 0, 2 * Q_ONE, 5 * Q_ONE, 0, 0, -Q_ONE, 4 * Q_ONE);
        cmd(ACT_SQUAD, 1, 0, 0, 0, 0, 3 * Q_ONE, -5);
        cmd(ACT_LINE, 1, 0, 0, 0, 0, 0, 0);
        cmd(ACT_SCUBIC, 1, 0, 0, 0, 0, Q_ONE, Q_ONE);
        cmd(ACT_UNUSED_LO, 0, 0, 0, 0, 0, 0, 0);
        cmd(ACT_SQUAD, 0, 0, 0, 0, 0, Q_MAX, Q_MIN);
        cmd(ACT_LINE, 1, 0, 0, 0, 0, Q_MAX, Q_MIN);
        cmd(ACT_CLOSE, 1, 0, 0, 0, 0, 0, 0);
        cmd(ACT_QUAD, 0, Q_MIN, Q_MAX, 0, 0, Q_MAX, Q_MIN);
        cmd(ACT_UNUSED_HI, 1, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        cmd(ACT_END, 1, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
    endtask

    task automatic test_invalid_paths();
        cmd(ACT_END, 0, 0, 0, 0, 0, 0, 0);
        cmd(ACT_LINE, 0, 0, 0, 0, 0, Q_ONE, Q_ONE);
        cmd(ACT_MOVE, 0, 0, 0, 0, 0, Q_ONE, Q_ONE);
        cmd(ACT_END, 0, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_line_caps();
        set_regs(32'd65536, 32'd0, 32'd0, 32'd1, 32'd65536);
        cmd(ACT_MOVE, 0, 0, 0, 0, 0, 3 * Q_ONE, Q_ONE);
        cmd(ACT_LINE, 1, 0, 0, 0, 0, 0, 0);
        cmd(ACT_MOVE, 0, 0, 0, 0, 0, Q_MAX, 0);
        cmd(ACT_HLINE, 1, 0, 0, 0, 0, 0, 0);
        cmd(ACT_CLOSE, 0, 0, 0, 0, 0, 0, 0);
        cmd(ACT_MOVE, 0, 0, 0, 0, 0, Q_ONE, 0);
        cmd(ACT_MOVE, 0, 0, 0, 0, 0, 2 * Q_ONE, 0);
        cmd(ACT_QUAD, 1, 0, 0, 0, 0, 0, 0);
        cmd(ACT_END, 0, 0, 0, 0, 0, 0, 0);
        set_regs(32'd65536, 32'd0, 32'd0, 32'd1, 32'h7FFF_FFFF);
        cmd(ACT_MOVE, 0, 0, 0, 0, 0, Q_ONE, Q_ONE);
        cmd(ACT_CUBIC, 1, 0, 0, 0, 0, 0, 0);
        cmd(ACT_END, 0, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_register_extremes();
        set_regs(32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd512);
        test_directed_segments();
        set_regs(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd256);
        test_directed_segments();
    endtask

    // Hold the receiver off long enough that the block's queue fills.
    task automatic test_output_stall();
        set_regs(32'd65536, 32'd0, 32'd0, 32'd0, 32'd0);
        send_idle_pct = 0;
        @(negedge aclk);
        stall_cycles = 400;
        cmd(ACT_MOVE, 0, 0, 0, 0, 0, 0, 0);
        repeat (12) rand_cmd(ACT_LINE);
        cmd(ACT_END, 0, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_random_paths();
        int items;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 45 : 0;
            recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 29 : 0;
            set_regs($urandom_range(1) ? $urandom : $urandom_range(32768, 262144),
                     $urandom, $urandom, $urandom_range(1),
                     $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 1 << 20));
            items = 0;
            while (items < 130) rand_path(items);
        end
    endtask

    initial begin
        clear_path();
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 29;
        recv_idle_pct = 45;
        test_directed_segments();
        test_invalid_paths();
        test_line_caps();
        test_register_extremes();
        test_output_stall();
        test_random_paths();
        drain();
        if (errors == 0 && expected_prims.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
